/* src/dtne_pkg.sv */
// Shared types and constants for the delimiter tokenizer with nested escapes.
`timescale 1ns / 1ps
`default_nettype none

package dtne_pkg;

    localparam int STACK_DEPTH = 16;
    localparam int NUM_PAIRS   = 3;
    localparam int LEVEL_W     = $clog2(STACK_DEPTH + 1);
    localparam int IDX_W       = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int ADDR_W      = 5;

    // Register indexes on the configuration port (byte address = 4 * index)
    localparam logic [2:0] REG_DELIMITER  = 3'd0;
    localparam logic [2:0] REG_PAIRS      = 3'd1;
    localparam logic [2:0] REG_OPEN_0     = 3'd2;
    localparam logic [2:0] REG_CLOSE_0    = 3'd3;
    localparam logic [2:0] REG_OPEN_1     = 3'd4;
    localparam logic [2:0] REG_CLOSE_1    = 3'd5;
    localparam logic [2:0] REG_OPEN_2     = 3'd6;
    localparam logic [2:0] REG_CLOSE_2    = 3'd7;

    localparam logic [7:0] DELIMITER_RESET = 8'd44;

    typedef struct packed {
        logic [7:0] char_in;
        logic       string_last;
    } in_item_t;

    typedef struct packed {
        logic [7:0] char_out;
        logic       in_token;
        logic       opens_token;
        logic       closes_previous;
        logic       ends_string;
        logic       stack_overflow;
    } out_item_t;

    typedef struct packed {
        logic [7:0]                 delimiter_byte;
        logic [1:0]                 pairs_in_use;
        logic [NUM_PAIRS-1:0][7:0]  open_byte;
        logic [NUM_PAIRS-1:0][7:0]  close_byte;
    } cfg_t;

endpackage

`default_nettype wire

/* src/dtne_cfg.sv */
// Configuration register file behind the APB-style port.
`timescale 1ns / 1ps
`default_nettype none

module dtne_cfg (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [dtne_pkg::ADDR_W-1:0] paddr,
    input  wire logic [31:0]                pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready,
    output dtne_pkg::cfg_t                  cfg
);

    dtne_pkg::cfg_t cfg_reg;
    logic [2:0]     reg_idx;
    logic           wr_en;

    assign reg_idx = paddr[4:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign cfg     = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '{delimiter_byte: dtne_pkg::DELIMITER_RESET,
                         pairs_in_use:   2'd0,
                         open_byte:      '0,
                         close_byte:     '0};
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                dtne_pkg::REG_DELIMITER: cfg_reg.delimiter_byte <= pwdata[7:0];
                dtne_pkg::REG_PAIRS:     cfg_reg.pairs_in_use   <= pwdata[1:0];
                dtne_pkg::REG_OPEN_0:    cfg_reg.open_byte[0]   <= pwdata[7:0];
                dtne_pkg::REG_CLOSE_0:   cfg_reg.close_byte[0]  <= pwdata[7:0];
                dtne_pkg::REG_OPEN_1:    cfg_reg.open_byte[1]   <= pwdata[7:0];
                dtne_pkg::REG_CLOSE_1:   cfg_reg.close_byte[1]  <= pwdata[7:0];
                dtne_pkg::REG_OPEN_2:    cfg_reg.open_byte[2]   <= pwdata[7:0];
                dtne_pkg::REG_CLOSE_2:   cfg_reg.close_byte[2]  <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            dtne_pkg::REG_DELIMITER: prdata = {24'd0, cfg_reg.delimiter_byte};
            dtne_pkg::REG_PAIRS:     prdata = {30'd0, cfg_reg.pairs_in_use};
            dtne_pkg::REG_OPEN_0:    prdata = {24'd0, cfg_reg.open_byte[0]};
            dtne_pkg::REG_CLOSE_0:   prdata = {24'd0, cfg_reg.close_byte[0]};
            dtne_pkg::REG_OPEN_1:    prdata = {24'd0, cfg_reg.open_byte[1]};
            dtne_pkg::REG_CLOSE_1:   prdata = {24'd0, cfg_reg.close_byte[1]};
            dtne_pkg::REG_OPEN_2:    prdata = {24'd0, cfg_reg.open_byte[2]};
            dtne_pkg::REG_CLOSE_2:   prdata = {24'd0, cfg_reg.close_byte[2]};
            default:                 prdata = 32'd0;
        endcase
    end

endmodule

`default_nettype wire

/* src/dtne_core.sv */
// Per-byte tokenizer step: escape stack, stack level and token state.
`timescale 1ns / 1ps
`default_nettype none

module dtne_core (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire dtne_pkg::cfg_t     cfg,
    input  wire dtne_pkg::in_item_t item,
    input  wire logic               advance,
    output dtne_pkg::out_item_t     result
);

    logic [1:0]                     stack_reg [dtne_pkg::STACK_DEPTH];
    logic [dtne_pkg::LEVEL_W-1:0]   stack_level_reg;
    logic [dtne_pkg::LEVEL_W-1:0]   stack_level_next;
    logic                           token_open_reg;
    logic                           token_open_next;

    logic [dtne_pkg::IDX_W-1:0]     top_ptr;
    logic [dtne_pkg::IDX_W-1:0]     push_ptr;
    logic [1:0]                     top_pair;
    logic [7:0]                     top_open;
    logic                           escaped;
    logic                           is_tok;
    logic                           push;
    logic                           pop;
    logic                           ovf;
    logic                           done;
    logic [1:0]                     push_idx;

    assign top_ptr  = dtne_pkg::IDX_W'(stack_level_reg - 1'b1);
    assign push_ptr = dtne_pkg::IDX_W'(stack_level_reg);
    assign top_pair = stack_reg[top_ptr];
    assign escaped  = (stack_level_reg != '0);
    assign is_tok   = (item.char_in != cfg.delimiter_byte) || escaped;

    always_comb
    begin
        case (top_pair)
            2'd0:    top_open = cfg.open_byte[0];
            2'd1:    top_open = cfg.open_byte[1];
            2'd2:    top_open = cfg.open_byte[2];
            default: top_open = 8'd0;
        endcase
    end

    // Scan the pairs in use, lowest first; an opener or a popping closer stops the scan
    always_comb
    begin
        push     = 1'b0;
        pop      = 1'b0;
        ovf      = 1'b0;
        done     = 1'b0;
        push_idx = 2'd0;
        for (int i = 0; i < dtne_pkg::NUM_PAIRS; i++)
        begin
            if (is_tok && !done && (2'(i) < cfg.pairs_in_use))
            begin
                if (item.char_in == cfg.open_byte[i])
                begin
                    done = 1'b1;
                    if (stack_level_reg < dtne_pkg::LEVEL_W'(dtne_pkg::STACK_DEPTH))
                    begin
                        push     = 1'b1;
                        push_idx = 2'(i);
                    end
                    else
                    begin
                        ovf = 1'b1;
                    end
                end
                else if (item.char_in == cfg.close_byte[i] && escaped
                         && top_open == cfg.open_byte[i])
                begin
                    pop  = 1'b1;
                    done = 1'b1;
                end
            end
        end
    end

    always_comb
    begin
        if (item.string_last)
            stack_level_next = '0;
        else if (push)
            stack_level_next = stack_level_reg + 1'b1;
        else if (pop)
            stack_level_next = stack_level_reg - 1'b1;
        else
            stack_level_next = stack_level_reg;
        token_open_next = is_tok && !item.string_last;
    end

    always_comb
    begin
        result.char_out        = item.char_in;
        result.in_token        = is_tok;
        result.opens_token     = is_tok && !token_open_reg;
        result.closes_previous = !is_tok && token_open_reg;
        result.ends_string     = item.string_last;
        result.stack_overflow  = ovf;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stack_level_reg <= '0;
            token_open_reg  <= 1'b0;
        end
        else if (advance)
        begin
            stack_level_reg <= stack_level_next;
            token_open_reg  <= token_open_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && push)
            stack_reg[push_ptr] <= push_idx;
    end

endmodule

`default_nettype wire

/* src/delimiter_tokenizer_with_nested_escapes.sv */
// Top level: input register, tokenizer step and result register.
//
//  channel  | direction | handshake            | payload
//  ---------+-----------+----------------------+---------------------------
//  in       | in        | in_valid / in_stall  | in_data (char_in, string_last)
//  out      | out       | out_valid / out_stall| out_data (char, flags)
//  config   | in        | APB psel/penable     | paddr, pwdata, prdata
//
// One byte per cycle sustained while out_stall is low; each byte is captured in the
// input register, and its result is loaded into the result register when the input
// stage advances, from where it is presented on the output.
// The step logic reads the stack top combinationally and registers level and token
// state as each byte advances, so consecutive bytes flow without bubbles.
// Reset clears stack level, token state, valid flags and config, not stack or data.
// out_stall holds the result register and, once the input register is full, the input.
`timescale 1ns / 1ps
`default_nettype none

module delimiter_tokenizer_with_nested_escapes (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_stall,
    input  wire dtne_pkg::in_item_t          in_data,
    output logic                             out_valid,
    input  wire logic                        out_stall,
    output dtne_pkg::out_item_t              out_data,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [dtne_pkg::ADDR_W-1:0] paddr,
    input  wire logic [31:0]                 pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready
);

    dtne_pkg::cfg_t         cfg;
    dtne_pkg::in_item_t     s1_item_reg;
    logic                   s1_valid_reg;
    dtne_pkg::out_item_t    out_item_reg;
    logic                   out_valid_reg;
    dtne_pkg::out_item_t    step_result;
    logic                   s1_adv;
    logic                   in_take;

    dtne_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    dtne_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .item    (s1_item_reg),
        .advance (s1_adv),
        .result  (step_result)
    );

    // Advance the input stage when the result register is free or being drained
    assign s1_adv    = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = s1_valid_reg && !s1_adv;
    assign in_take   = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign out_data  = out_item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_take)
                s1_valid_reg <= 1'b1;
            else if (s1_adv)
                s1_valid_reg <= 1'b0;

            if (s1_adv)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
            s1_item_reg <= in_data;
        if (s1_adv)
            out_item_reg <= step_result;
    end

endmodule

`default_nettype wire
